// ===== design/acs_pkg.sv =====
// Shared types and constants for the ABR destination cell sink.
`default_nettype none
package acs_pkg;

    typedef enum logic [1:0] {
        REQ_DATA   = 2'd0,
        REQ_RM     = 2'd1,
        REQ_RESUME = 2'd2,
        REQ_TICK   = 2'd3
    } req_kind_t;

    localparam logic OUT_DATA = 1'b0;
    localparam logic OUT_RM   = 1'b1;

    localparam logic [2:0] CFG_TARGET   = 3'd0;
    localparam logic [2:0] CFG_HIGH     = 3'd1;
    localparam logic [2:0] CFG_LOW      = 3'd2;
    localparam logic [2:0] CFG_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_ER_CELL  = 3'd4;
    localparam logic [2:0] CFG_PEAK     = 3'd5;
    localparam logic [2:0] CFG_MINIMUM  = 3'd6;
    localparam logic [2:0] CFG_VCI      = 3'd7;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [23:0] RATE_MAX  = 24'hFFFFFF;
    localparam logic [15:0] LOAD_MAX  = 16'hFFFF;
    localparam logic [31:0] DROP_MAX  = 32'hFFFFFFFF;

    typedef struct packed {
        logic        kind;
        logic [15:0] tag;
        logic [23:0] er;
        logic        ci;
        logic        clp;
        logic [15:0] vci;
        logic [10:0] qlen;
        logic [31:0] lost;
    } entry_t;

endpackage
`default_nettype wire

// ===== design/abr_destination_cell_sink_top.sv =====
// Top level of the ABR destination cell sink.
// Takes data cells, forward RM cells, resume events and slot ticks, one transfer
// per clock while s_tready is high. Data cells go downstream at most one per
// slot, otherwise wait in a BUFFER_DEPTH-entry buffer memory or are dropped and
// counted when it is full; RM cells are turned back with CI and ER set from the
// queue length and the measured output rate. A transfer yields at most one
// result, which passes the front-end stage register (beside the registered read
// port of the buffer memory), the result queue and the output register. The
// buffer needs no clearing after reset. Configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata while the block is idle.
`default_nettype none
module abr_destination_cell_sink_top #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // cell_tag[15:0], rm_er[39:16], rm_ci[40], rm_clp[41], downstream_stop[42]
    input  wire logic [47:0]   s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // out_tag[15:0], out_er[39:16], out_ci[40], out_clp[41], out_vci[57:42],
    // queue_length[68:58], lost_count[100:69]
    output logic [103:0]       m_tdata,
    // out_kind[0]
    output logic               m_tuser
);
    import acs_pkg::*;

    logic               in_accept;
    logic               push_valid;
    entry_t             push_entry;
    logic               inflight;
    logic               head_valid;
    entry_t             head_entry;
    logic               pop;
    logic [Q_CNT_W-1:0] q_count;

    assign s_tready  = (32'(q_count) + 32'(inflight)) < Q_DEPTH;
    assign in_accept = s_tvalid && s_tready;

    acs_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .in_kind    (s_tuser),
        .in_tag     (s_tdata[15:0]),
        .in_rm_er   (s_tdata[39:16]),
        .in_rm_ci   (s_tdata[40]),
        .in_rm_clp  (s_tdata[41]),
        .in_stop    (s_tdata[42]),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .inflight   (inflight)
    );

    acs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (q_count)
    );

    acs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

// ===== design/acs_front.sv =====
// Front end: configuration, cell classification, buffer and rate measurement.
`default_nettype none
module acs_front #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [2:0]     cfg_addr,
    input  wire logic [31:0]    cfg_wdata,
    input  wire logic           in_accept,
    input  wire logic [1:0]     in_kind,
    input  wire logic [15:0]    in_tag,
    input  wire logic [23:0]    in_rm_er,
    input  wire logic           in_rm_ci,
    input  wire logic           in_rm_clp,
    input  wire logic           in_stop,
    output logic                push_valid,
    output acs_pkg::entry_t     push_entry,
    output logic                inflight
);
    import acs_pkg::*;

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    logic [10:0] target_reg, high_reg, low_reg;
    logic [15:0] interval_reg;
    logic [31:0] er_cell_reg;
    logic [23:0] peak_reg, minimum_reg;
    logic [15:0] vci_reg;

    logic [PTR_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             congested_reg, congested_next;
    logic             stopped_reg, stopped_next;
    logic             sent_reg, sent_next;
    logic [15:0]      load_reg, load_next;
    logic [15:0]      slot_reg, slot_next;
    logic [23:0]      meas_reg, meas_next;
    logic [31:0]      drop_reg, drop_next;

    logic [15:0]      mem [BUFFER_DEPTH];
    logic [15:0]      rd_data_reg;
    logic             wr_en, rd_en;

    logic             s1_valid_reg;
    logic             s1_from_mem_reg;
    entry_t           s1_entry_reg;

    logic             emit;
    logic             from_mem;
    entry_t           ent;

    logic [15:0]      load_inc, tick_load;
    logic             tick_fwd;
    logic [47:0]      prod;
    logic [23:0]      meas_sat;
    logic [23:0]      limit;
    logic [31:0]      fill_ext, fill_next_ext;
    logic [16:0]      slot_inc;

    always_comb begin
        fill_ext  = 32'(fill_reg);
        load_inc  = (load_reg == LOAD_MAX) ? load_reg : load_reg + 16'd1;
        tick_fwd  = !stopped_reg && (fill_reg != '0);
        tick_load = tick_fwd ? load_inc : load_reg;
        prod      = 48'(er_cell_reg) * 48'(tick_load);
        meas_sat  = (|prod[47:32]) ? RATE_MAX : prod[31:8];
        slot_inc  = 17'(slot_reg) + 17'd1;
        limit     = (fill_ext >= 32'(target_reg)) ? meas_reg : peak_reg;
        if (limit < minimum_reg) begin
            limit = minimum_reg;
        end
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        congested_next = congested_reg;
        stopped_next   = stopped_reg;
        sent_next      = sent_reg;
        load_next      = load_reg;
        slot_next      = slot_reg;
        meas_next      = meas_reg;
        drop_next      = drop_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        emit           = 1'b0;
        from_mem       = 1'b0;
        ent            = '0;
        if (in_accept) begin
            case (req_kind_t'(in_kind))
                REQ_DATA: begin
                    if (!stopped_reg && fill_reg == '0 && !sent_reg) begin
                        stopped_next = in_stop;
                        load_next    = load_inc;
                        sent_next    = 1'b1;
                        emit         = 1'b1;
                        ent.kind     = OUT_DATA;
                        ent.tag      = in_tag;
                    end else if (fill_ext < BUFFER_DEPTH) begin
                        wr_en     = 1'b1;
                        tail_next = (32'(tail_reg) + 32'd1 >= BUFFER_DEPTH) ?
                                    '0 : tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end else if (drop_reg != DROP_MAX) begin
                        drop_next = drop_reg + 32'd1;
                    end
                end
                REQ_RM: begin
                    ent.ci = in_rm_ci;
                    if (congested_reg) begin
                        if (fill_ext <= 32'(low_reg)) begin
                            congested_next = 1'b0;
                        end else begin
                            ent.ci = 1'b1;
                        end
                    end else if (fill_ext > 32'(high_reg)) begin
                        congested_next = 1'b1;
                        ent.ci         = 1'b1;
                    end
                    emit     = 1'b1;
                    ent.kind = OUT_RM;
                    ent.er   = (in_rm_er > limit) ? limit : in_rm_er;
                    ent.clp  = in_rm_clp;
                    ent.vci  = vci_reg;
                end
                REQ_RESUME: begin
                    stopped_next = 1'b0;
                end
                REQ_TICK: begin
                    sent_next = 1'b0;
                    if (tick_fwd) begin
                        rd_en        = 1'b1;
                        head_next    = (32'(head_reg) + 32'd1 >= BUFFER_DEPTH) ?
                                       '0 : head_reg + 1'b1;
                        fill_next    = fill_reg - 1'b1;
                        stopped_next = in_stop;
                        sent_next    = 1'b1;
                        load_next    = tick_load;
                        emit         = 1'b1;
                        from_mem     = 1'b1;
                        ent.kind     = OUT_DATA;
                    end
                    if (slot_inc >= 17'(interval_reg)) begin
                        meas_next = meas_sat;
                        load_next = '0;
                        slot_next = '0;
                    end else begin
                        slot_next = slot_inc[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
        fill_next_ext = 32'(fill_next);
        ent.qlen      = fill_next_ext[10:0];
        ent.lost      = drop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= 11'd512;
            high_reg     <= 11'd1024;
            low_reg      <= 11'd1024;
            interval_reg <= 16'd30;
            er_cell_reg  <= 32'd3013971;
            peak_reg     <= 24'd353207;
            minimum_reg  <= '0;
            vci_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TARGET:   target_reg   <= cfg_wdata[10:0];
                CFG_HIGH:     high_reg     <= cfg_wdata[10:0];
                CFG_LOW:      low_reg      <= cfg_wdata[10:0];
                CFG_INTERVAL: interval_reg <= cfg_wdata[15:0];
                CFG_ER_CELL:  er_cell_reg  <= cfg_wdata;
                CFG_PEAK:     peak_reg     <= cfg_wdata[23:0];
                CFG_MINIMUM:  minimum_reg  <= cfg_wdata[23:0];
                CFG_VCI:      vci_reg      <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            congested_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            sent_reg      <= 1'b0;
            load_reg      <= '0;
            slot_reg      <= '0;
            meas_reg      <= '0;
            drop_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            congested_reg <= congested_next;
            stopped_reg   <= stopped_next;
            sent_reg      <= sent_next;
            load_reg      <= load_next;
            slot_reg      <= slot_next;
            meas_reg      <= meas_next;
            drop_reg      <= drop_next;
            s1_valid_reg  <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_entry_reg    <= ent;
        s1_from_mem_reg <= from_mem;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= in_tag;
        end
        if (rd_en) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_comb begin
        push_valid = s1_valid_reg;
        push_entry = s1_entry_reg;
        if (s1_from_mem_reg) begin
            push_entry.tag = rd_data_reg;
        end
        inflight = s1_valid_reg;
    end

endmodule
`default_nettype wire

// ===== design/acs_queue.sv =====
// Short result queue between the front end and the output stage.
`default_nettype none
module acs_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire acs_pkg::entry_t    push_entry,
    input  wire logic               pop,
    output logic                    head_valid,
    output acs_pkg::entry_t         head_entry,
    output logic [acs_pkg::Q_CNT_W-1:0] count
);
    import acs_pkg::*;

    entry_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== design/acs_back.sv =====
// Output stage: holds one result and drives the master stream.
`default_nettype none
module acs_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               head_valid,
    input  wire acs_pkg::entry_t    head_entry,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [103:0]            m_tdata,
    output logic                    m_tuser
);
    import acs_pkg::*;

    logic   out_valid_reg;
    entry_t out_reg;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'b000, out_reg.lost, out_reg.qlen, out_reg.vci, out_reg.clp,
                       out_reg.ci, out_reg.er, out_reg.tag};

endmodule
`default_nettype wire

// ===== sim/tb_abr_destination_cell_sink_top.sv =====
// Self-checking testbench for the ABR destination cell sink: stream stimulus, predictor, scoreboard.
module tb_abr_destination_cell_sink_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int LONG_SLOTS = 20;

    typedef struct {
        logic [31:0] target;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] interval;
        logic [31:0] er_cell;
        logic [31:0] peak;
        logic [31:0] minimum;
        logic [31:0] vci;
    } sink_cfg_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_THREE_OF_FOUR,
        RX_RANDOM,
        RX_HALF
    } rx_mode_t;

    class sink_scoreboard;
        logic [10:0] target_buffer;
        logic [10:0] high_threshold;
        logic [10:0] low_threshold;
        logic [15:0] interval_slots;
        logic [31:0] er_per_cell;
        logic [23:0] peak_rate;
        logic [23:0] minimum_rate;
        logic [15:0] backward_vci;

        logic [15:0] cell_store [DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        bit          congested;
        bit          stopped;
        bit          sent_in_slot;
        int unsigned slot_load;
        int unsigned slot_count;
        logic [23:0] rate_measured;
        logic [31:0] drops;

        entry_t      expected_out [$];
        int          errors;

        function new();
            target_buffer  = 11'd512;
            high_threshold = 11'd1024;
            low_threshold  = 11'd1024;
            interval_slots = 16'd30;
            er_per_cell    = 32'd3013971;
            peak_rate      = 24'd353207;
            minimum_rate   = '0;
            backward_vci   = '0;
            head = 0; tail = 0; fill = 0;
            congested = 0; stopped = 0; sent_in_slot = 0;
            slot_load = 0; slot_count = 0;
            rate_measured = '0;
            drops = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_TARGET:   target_buffer  = val[10:0];
                CFG_HIGH:     high_threshold = val[10:0];
                CFG_LOW:      low_threshold  = val[10:0];
                CFG_INTERVAL: interval_slots = val[15:0];
                CFG_ER_CELL:  er_per_cell    = val;
                CFG_PEAK:     peak_rate      = val[23:0];
                CFG_MINIMUM:  minimum_rate   = val[23:0];
                CFG_VCI:      backward_vci   = val[15:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic kind, logic [15:0] tag, logic [23:0] er, logic ci,
                                  logic clp, logic [15:0] vci);
            entry_t e;
            e.kind = kind;
            e.tag  = tag;
            e.er   = er;
            e.ci   = ci;
            e.clp  = clp;
            e.vci  = vci;
            e.qlen = 11'(fill);
            e.lost = drops;
            expected_out.push_back(e);
        endfunction

        function void note_forward(logic stop);
            stopped = stop;
            if (slot_load < 32'hFFFF)
                slot_load++;
            sent_in_slot = 1;
        endfunction

        function void record_input(req_kind_t kind, logic [15:0] tag, logic [23:0] rate,
                                   logic ci, logic clp, logic stop);
            int unsigned limit;
            logic        ci_out;
            logic [15:0] head_tag;
            logic [63:0] product;
            case (kind)
                REQ_DATA: begin
                    if (!stopped && fill == 0 && !sent_in_slot) begin
                        note_forward(stop);
                        push_result(OUT_DATA, tag, '0, 1'b0, 1'b0, '0);
                    end else if (fill < DEPTH) begin
                        cell_store[tail] = tag;
                        tail = (tail + 1) % DEPTH;
                        fill++;
                    end else if (drops != DROP_MAX) begin
                        drops++;
                    end
                end
                REQ_RM: begin
                    ci_out = ci;
                    if (congested) begin
                        if (fill <= low_threshold) congested = 0;
                        else ci_out = 1'b1;
                    end else if (fill > high_threshold) begin
                        congested = 1;
                        ci_out = 1'b1;
                    end
                    limit = (fill >= target_buffer) ? rate_measured : peak_rate;
                    if (limit < minimum_rate) limit = minimum_rate;
                    push_result(OUT_RM, '0, (rate > limit) ? 24'(limit) : rate, ci_out, clp,
                                backward_vci);
                end
                REQ_RESUME: stopped = 0;
                default: begin
                    sent_in_slot = 0;
                    if (!stopped && fill > 0) begin
                        head_tag = cell_store[head];
                        head = (head + 1) % DEPTH;
                        fill--;
                        note_forward(stop);
                        push_result(OUT_DATA, head_tag, '0, 1'b0, 1'b0, '0);
                    end
                    slot_count++;
                    if (slot_count >= interval_slots) begin
                        product = (64'(er_per_cell) * 64'(slot_load)) >> 8;
                        rate_measured = (product > 64'(RATE_MAX)) ? RATE_MAX : product[23:0];
                        slot_load = 0;
                        slot_count = 0;
                    end
                end
            endcase
        endfunction

        function void check_output(logic kind, logic [103:0] d);
            entry_t got;
            entry_t want;
            got.kind = kind;
            got.tag  = d[15:0];
            got.er   = d[39:16];
            got.ci   = d[40];
            got.clp  = d[41];
            got.vci  = d[57:42];
            got.qlen = d[68:58];
            got.lost = d[100:69];
            if (expected_out.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: kind=%0d tag=%h er=%h ci=%0d clp=%0d vci=%h qlen=%0d lost=%0d",
                             got.kind, got.tag, got.er, got.ci, got.clp, got.vci, got.qlen,
                             got.lost);
                return;
            end
            want = expected_out.pop_front();
            if (got.kind !== want.kind || got.tag !== want.tag || got.er !== want.er ||
                got.ci !== want.ci || got.clp !== want.clp || got.vci !== want.vci ||
                got.qlen !== want.qlen || got.lost !== want.lost) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: kind=%0d tag=%h er=%h ci=%0d clp=%0d vci=%h qlen=%0d lost=%0d",
                             want.kind, want.tag, want.er, want.ci, want.clp, want.vci,
                             want.qlen, want.lost);
                    $display("         got: kind=%0d tag=%h er=%h ci=%0d clp=%0d vci=%h qlen=%0d lost=%0d",
                             got.kind, got.tag, got.er, got.ci, got.clp, got.vci, got.qlen,
                             got.lost);
                end
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn   = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [2:0]    cfg_addr  = '0;
    logic [31:0]   cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [47:0]   s_tdata   = '0;
    logic [1:0]    s_tuser   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [103:0]  m_tdata;
    logic          m_tuser;

    logic [15:0]   ready_count = '0;
    rx_mode_t      ready_mode  = RX_ALWAYS;
    int            burst_left  = 0;
    sink_scoreboard sb;

    abr_destination_cell_sink_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("tb_abr_destination_cell_sink_top: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        ready_count <= ready_count + 16'd1;
        if (ready_count[8:0] == '0)
            ready_mode <= rx_mode_t'($urandom_range(3, 0));
        case (ready_mode)
            RX_ALWAYS:        m_tready <= 1'b1;
            RX_THREE_OF_FOUR: m_tready <= (ready_count[1:0] != 2'b11);
            RX_RANDOM:        m_tready <= ($urandom_range(3, 0) != 0);
            default:          m_tready <= ~ready_count[2];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_output(m_tuser, m_tdata);
    end

    task automatic send_item(input req_kind_t kind, input logic [15:0] tag,
                             input logic [23:0] rate, input logic ci, input logic clp,
                             input logic stop);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(32, 1);
            if ($urandom_range(3, 0) != 0)
                gap = $urandom_range(6, 1);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, stop, clp, ci, rate, tag};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.record_input(kind, tag, rate, ci, clp, stop);
    endtask

    task automatic send_rm();
        logic [23:0] rate;
        case ($urandom_range(7, 0))
            0:       rate = '0;
            1:       rate = RATE_MAX;
            default: rate = 24'($urandom);
        endcase
        send_item(REQ_RM, '0, rate, 1'($urandom), 1'($urandom), 1'b0);
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 4)
            send_item(REQ_DATA, 16'($urandom), 24'($urandom), 1'($urandom), 1'($urandom),
                      $urandom_range(7, 0) == 0);
        else if (pick < 7)
            send_item(REQ_TICK, 16'($urandom), 24'($urandom), 1'($urandom), 1'($urandom),
                      $urandom_range(7, 0) == 0);
        else if (pick < 9)
            send_rm();
        else
            send_item(REQ_RESUME, 16'($urandom), 24'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_out.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input sink_cfg_t c);
        drain();
        write_reg(CFG_TARGET,   c.target);
        write_reg(CFG_HIGH,     c.high);
        write_reg(CFG_LOW,      c.low);
        write_reg(CFG_INTERVAL, c.interval);
        write_reg(CFG_ER_CELL,  c.er_cell);
        write_reg(CFG_PEAK,     c.peak);
        write_reg(CFG_MINIMUM,  c.minimum);
        write_reg(CFG_VCI,      c.vci);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sink_cfg_t random_cfg();
        sink_cfg_t c;
        c.target   = $urandom_range(DEPTH, 1);
        c.high     = $urandom_range(40, 1);
        c.low      = $urandom_range(c.high, 0);
        c.interval = $urandom_range(40, 1);
        c.er_cell  = $urandom;
        c.peak     = 24'($urandom);
        c.minimum  = ($urandom_range(1, 0) == 0) ? 32'd0 : 32'(24'($urandom)) >> 4;
        c.vci      = 16'($urandom);
        return c;
    endfunction

    initial begin
        sink_cfg_t c;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, stop and resume, reset configuration
        send_item(REQ_DATA,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_DATA,   16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b0);
        send_item(REQ_RM,     16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        send_item(REQ_RM,     16'h0000, 24'h000000, 1'b1, 1'b1, 1'b1);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b1);
        send_item(REQ_DATA,   16'hA5A5, 24'h5A5A5A, 1'b0, 1'b1, 1'b0);
        send_item(REQ_DATA,   16'h5A5A, 24'hA5A5A5, 1'b1, 1'b0, 1'b1);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_RM,     16'h0000, 24'h123456, 1'b0, 1'b1, 1'b0);
        send_item(REQ_RESUME, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_DATA,   16'h1234, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_DATA,   16'h8001, 24'h000000, 1'b0, 1'b0, 1'b1);
        send_item(REQ_DATA,   16'h7FFE, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_RESUME, 16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_DATA,   16'hC3C3, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK,   16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0);
        send_item(REQ_RM,     16'h0000, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);

        // queue cells while stopped past the congestion threshold, then drain the buffer
        c = '{target: 1, high: 20, low: 8, interval: 3, er_cell: 32'hFFFFFFFF,
              peak: 32'hFFFFFF, minimum: 5000, vci: 32'hFFFF};
        configure(c);
        send_item(REQ_RESUME, '0, '0, 1'b0, 1'b0, 1'b0);
        send_item(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b1);
        send_item(REQ_DATA, 16'($urandom), '0, 1'b0, 1'b0, 1'b1);
        repeat (40) begin
            if ($urandom_range(7, 0) == 0)
                send_rm();
            else
                send_item(REQ_DATA, 16'($urandom), 24'($urandom), 1'b0, 1'b0, 1'($urandom));
        end
        send_item(REQ_RESUME, '0, '0, 1'b0, 1'b0, 1'b0);
        while (sb.fill > 0) begin
            case ($urandom_range(7, 0))
                0:       send_rm();
                1:       send_item(REQ_DATA, 16'($urandom), '0, 1'b0, 1'b0, 1'b0);
                default: send_item(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
            endcase
        end
        send_rm();

        // close an interval with an empty queue, then run a full interval with a steady load
        c = '{target: 1, high: 1024, low: 1024, interval: 1, er_cell: 256,
              peak: 0, minimum: 0, vci: 0};
        configure(c);
        send_item(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
        c.interval = LONG_SLOTS;
        configure(c);
        send_item(REQ_DATA, 16'($urandom), '0, 1'b0, 1'b0, 1'b0);
        send_item(REQ_DATA, 16'($urandom), '0, 1'b0, 1'b0, 1'b0);
        repeat (LONG_SLOTS) begin
            send_item(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
            send_item(REQ_DATA, 16'($urandom), '0, 1'b0, 1'b0, 1'b0);
        end
        send_item(REQ_RM, '0, RATE_MAX, 1'b0, 1'b0, 1'b0);

        // random traffic under several settings
        c = '{target: 1, high: 1, low: 0, interval: 0, er_cell: 0,
              peak: 0, minimum: 0, vci: 0};
        configure(c);
        repeat (60) send_random();
        c = '{target: 1024, high: 1024, low: 1024, interval: 32'hFFFF, er_cell: 32'hFFFFFFFF,
              peak: 32'hFFFFFF, minimum: 32'hFFFFFF, vci: 32'hFFFF};
        configure(c);
        repeat (60) send_random();
        repeat (2) begin
            configure(random_cfg());
            repeat (60) send_random();
        end

        drain();
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("tb_abr_destination_cell_sink_top: done, clean");
        else
            $display("tb_abr_destination_cell_sink_top: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/acs_pkg.sv
design/acs_front.sv
design/acs_queue.sv
design/acs_back.sv
design/abr_destination_cell_sink_top.sv
sim/tb_abr_destination_cell_sink_top.sv
